// ----- design/pcpf_pkg.sv -----
// ----------------------------------------------------------------------------
// pcpf_pkg: shared types and constants of the per-CPU page free list
// Command, status and register codes, and the control and status groups
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pcpf_pkg;

  localparam int PAGE_W     = 15;
  localparam int LINK_W     = 16;
  localparam int CPU_ID_W   = 3;
  localparam int STATUS_W   = 2;
  localparam int LIMIT_W    = 8;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic CMD_FREE  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_MEM   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_ADDR = 2'd2;

  localparam logic REG_STEAL_LIMIT = 1'b0;
  localparam logic REG_LOWEST_PAGE = 1'b1;

  localparam logic [LIMIT_W-1:0] STEAL_LIMIT_RESET = 8'd64;
  localparam logic [PAGE_W-1:0]  LOWEST_PAGE_RESET = 15'd0;

  typedef struct packed {
    logic                load_in;
    logic                free_push;
    logic                rd_issue;
    logic                rd_victim;
    logic                pop_commit;
    logic                move_commit;
    logic                steal_init;
    logic                v_inc;
    logic                res_load;
    logic [STATUS_W-1:0] res_code;
    logic                res_grant;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic cpu_ok;
    logic free_ok;
    logic own_nonempty;
    logic scan_done;
    logic victim_ready;
    logic out_free;
  } dp_status_t;

endpackage

// ----- design/pcpf_regs.sv -----
// ----------------------------------------------------------------------------
// pcpf_regs: configuration registers
// APB-style register file holding the steal limit and the lowest page.
// ----------------------------------------------------------------------------
module pcpf_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pcpf_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [pcpf_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [pcpf_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  output logic [pcpf_pkg::LIMIT_W-1:0]       steal_limit,
  output logic [pcpf_pkg::PAGE_W-1:0]        lowest_page
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      steal_limit <= pcpf_pkg::STEAL_LIMIT_RESET;
      lowest_page <= pcpf_pkg::LOWEST_PAGE_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        pcpf_pkg::REG_STEAL_LIMIT: steal_limit <= pwdata[pcpf_pkg::LIMIT_W-1:0];
        pcpf_pkg::REG_LOWEST_PAGE: lowest_page <= pwdata[pcpf_pkg::PAGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      pcpf_pkg::REG_STEAL_LIMIT:
        prdata = {{(pcpf_pkg::APB_DATA_W - pcpf_pkg::LIMIT_W){1'b0}}, steal_limit};
      pcpf_pkg::REG_LOWEST_PAGE:
        prdata = {{(pcpf_pkg::APB_DATA_W - pcpf_pkg::PAGE_W){1'b0}}, lowest_page};
      default:
        prdata = '0;
    endcase
  end

endmodule

// ----- design/pcpf_ctrl.sv -----
// ----------------------------------------------------------------------------
// pcpf_ctrl: request sequencer
// Steps each request through decode and, as needed, the steal walk and the
// final pop, and issues datapath commands.
// ----------------------------------------------------------------------------
module pcpf_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  pcpf_pkg::dp_status_t   dp_status,
  output pcpf_pkg::ctrl_cmd_t    ctrl_cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_MOVE   = 3'd3;
  localparam logic [2:0] S_POP    = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl_cmd   = '0;
    ctrl_cmd.res_code = pcpf_pkg::STATUS_OK;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctrl_cmd.load_in = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!dp_status.is_alloc) begin
          if (dp_status.out_free) begin
            ctrl_cmd.free_push = dp_status.free_ok;
            ctrl_cmd.res_load  = 1'b1;
            ctrl_cmd.res_code  = dp_status.free_ok ? pcpf_pkg::STATUS_OK
                                                   : pcpf_pkg::STATUS_BAD_ADDR;
            state_next = S_IDLE;
          end
        end else if (!dp_status.cpu_ok) begin
          if (dp_status.out_free) begin
            ctrl_cmd.res_load = 1'b1;
            ctrl_cmd.res_code = pcpf_pkg::STATUS_NO_MEM;
            state_next = S_IDLE;
          end
        end else if (dp_status.own_nonempty) begin
          ctrl_cmd.rd_issue = 1'b1;
          state_next = S_POP;
        end else begin
          ctrl_cmd.steal_init = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (dp_status.scan_done) begin
          if (dp_status.own_nonempty) begin
            ctrl_cmd.rd_issue = 1'b1;
            state_next = S_POP;
          end else if (dp_status.out_free) begin
            ctrl_cmd.res_load = 1'b1;
            ctrl_cmd.res_code = pcpf_pkg::STATUS_NO_MEM;
            state_next = S_IDLE;
          end
        end else if (dp_status.victim_ready) begin
          ctrl_cmd.rd_issue  = 1'b1;
          ctrl_cmd.rd_victim = 1'b1;
          state_next = S_MOVE;
        end else begin
          ctrl_cmd.v_inc = 1'b1;
        end
      end
      S_MOVE: begin
        ctrl_cmd.move_commit = 1'b1;
        state_next = S_SCAN;
      end
      S_POP: begin
        if (dp_status.out_free) begin
          ctrl_cmd.pop_commit = 1'b1;
          ctrl_cmd.res_load   = 1'b1;
          ctrl_cmd.res_grant  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/pcpf_dpath.sv -----
// ----------------------------------------------------------------------------
// pcpf_dpath: free list datapath
// List heads, nonempty flags, the next-link memory, steal counters and the
// result register.
// ----------------------------------------------------------------------------
module pcpf_dpath #(
  parameter int NUM_CPUS  = 8,
  parameter int NUM_PAGES = 32768
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               command,
  input  logic [pcpf_pkg::CPU_ID_W-1:0]      cpu_id,
  input  logic [pcpf_pkg::PAGE_W-1:0]        page_index,
  input  logic [pcpf_pkg::LIMIT_W-1:0]       steal_limit,
  input  logic [pcpf_pkg::PAGE_W-1:0]        lowest_page,
  input  pcpf_pkg::ctrl_cmd_t                ctrl_cmd,
  output pcpf_pkg::dp_status_t               dp_status,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [pcpf_pkg::STATUS_W-1:0]      status,
  output logic [pcpf_pkg::PAGE_W-1:0]        granted_page
);

  localparam int MAX_PAGES = 1 << pcpf_pkg::PAGE_W;
  localparam int MEM_DEPTH = (NUM_PAGES < MAX_PAGES) ? NUM_PAGES : MAX_PAGES;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int CPU_W     = $clog2(NUM_CPUS);
  localparam int VCNT_W    = $clog2(NUM_CPUS + 1);
  localparam int CMP_W     = 21;
  localparam logic [CMP_W-1:0]  NUM_PAGES_L = CMP_W'(NUM_PAGES);
  localparam logic [6:0]        NUM_CPUS_L  = 7'(NUM_CPUS);
  localparam logic [VCNT_W-1:0] V_END       = VCNT_W'(NUM_CPUS);

  logic                          cmd_r;
  logic [pcpf_pkg::CPU_ID_W-1:0] cpu_r;
  logic [pcpf_pkg::PAGE_W-1:0]   page_r;

  logic [pcpf_pkg::PAGE_W-1:0]   head [NUM_CPUS];
  logic [NUM_CPUS-1:0]           nonempty;
  logic [pcpf_pkg::LINK_W-1:0]   link_mem [MEM_DEPTH];
  logic [pcpf_pkg::LINK_W-1:0]   rdata;

  logic [pcpf_pkg::PAGE_W-1:0]   move_page;
  logic [pcpf_pkg::LIMIT_W-1:0]  left;
  logic [VCNT_W-1:0]             v;

  logic [CPU_W-1:0]              cpu_idx;
  logic [CPU_W-1:0]              v_idx;
  logic [pcpf_pkg::PAGE_W-1:0]   head_rd;
  logic [pcpf_pkg::LINK_W-1:0]   push_link;
  logic                          mem_we;
  logic [ADDR_W-1:0]             wr_addr;
  logic                          cpu_ok;
  logic                          out_free;

  assign cpu_idx   = CPU_W'(cpu_r);
  assign v_idx     = v[CPU_W-1:0];
  assign head_rd   = ctrl_cmd.rd_victim ? head[v_idx] : head[cpu_idx];
  assign push_link = nonempty[cpu_idx] ? {1'b1, head[cpu_idx]} : '0;
  assign mem_we    = ctrl_cmd.free_push || ctrl_cmd.move_commit;
  assign wr_addr   = ctrl_cmd.free_push ? ADDR_W'(page_r) : ADDR_W'(move_page);
  assign cpu_ok    = {4'd0, cpu_r} < NUM_CPUS_L;
  assign out_free  = !out_valid || !out_stall;

  assign dp_status.is_alloc     = (cmd_r == pcpf_pkg::CMD_ALLOC);
  assign dp_status.cpu_ok       = cpu_ok;
  assign dp_status.free_ok      = cpu_ok && (page_r >= lowest_page)
                                  && ({6'd0, page_r} < NUM_PAGES_L);
  assign dp_status.own_nonempty = nonempty[cpu_idx];
  assign dp_status.scan_done    = (left == '0) || (v == V_END);
  assign dp_status.victim_ready = (v_idx != cpu_idx) && nonempty[v_idx];
  assign dp_status.out_free     = out_free;

  always_ff @(posedge clk) begin
    if (ctrl_cmd.load_in) begin
      cmd_r  <= command;
      cpu_r  <= cpu_id;
      page_r <= page_index;
    end
    if (ctrl_cmd.rd_issue) begin
      move_page <= head_rd;
    end
    if (ctrl_cmd.steal_init) begin
      left <= steal_limit;
      v    <= '0;
    end else begin
      if (ctrl_cmd.v_inc) begin
        v <= v + 1'b1;
      end
      if (ctrl_cmd.move_commit) begin
        left <= left - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[wr_addr] <= push_link;
    end
    if (ctrl_cmd.rd_issue) begin
      rdata <= link_mem[ADDR_W'(head_rd)];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.free_push) begin
      head[cpu_idx] <= page_r;
    end
    if (ctrl_cmd.pop_commit) begin
      head[cpu_idx] <= rdata[pcpf_pkg::PAGE_W-1:0];
    end
    if (ctrl_cmd.move_commit) begin
      head[v_idx]   <= rdata[pcpf_pkg::PAGE_W-1:0];
      head[cpu_idx] <= move_page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nonempty <= '0;
    end else begin
      if (ctrl_cmd.free_push) begin
        nonempty[cpu_idx] <= 1'b1;
      end
      if (ctrl_cmd.pop_commit) begin
        nonempty[cpu_idx] <= rdata[pcpf_pkg::LINK_W-1];
      end
      if (ctrl_cmd.move_commit) begin
        nonempty[v_idx]   <= rdata[pcpf_pkg::LINK_W-1];
        nonempty[cpu_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl_cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.res_load) begin
      status       <= ctrl_cmd.res_code;
      granted_page <= ctrl_cmd.res_grant ? move_page : '0;
    end
  end

endmodule

// ----- design/per_cpu_page_free_list_with_steal.sv -----
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_with_steal: per-CPU page allocator with stealing
// One LIFO free list per CPU in a shared next-link memory. An allocation
// that finds its own list empty first moves pages over from the other CPUs.
//
//   Channel   Signals                                  Direction
//   in        in_valid, in_stall, command, cpu_id,     request in
//             page_index
//   out       out_valid, out_stall, status,            result out
//             granted_page
//   cfg       psel, penable, pwrite, paddr, pwdata,    register access
//             prdata, pready
//
// An allocation that steals moves each page by a link memory read, then a
// write; one that finds nothing returns the no-memory status.
// Reset empties every list at once through the nonempty flags.
// The input stalls from acceptance until the result is loaded; a finished
// request waits while the output register still holds a stalled result.
// ----------------------------------------------------------------------------
module per_cpu_page_free_list_with_steal #(
  parameter int NUM_CPUS  = 8,
  parameter int NUM_PAGES = 32768
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               command,
  input  logic [pcpf_pkg::CPU_ID_W-1:0]      cpu_id,
  input  logic [pcpf_pkg::PAGE_W-1:0]        page_index,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [pcpf_pkg::STATUS_W-1:0]      status,
  output logic [pcpf_pkg::PAGE_W-1:0]        granted_page,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pcpf_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [pcpf_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [pcpf_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);

  logic [pcpf_pkg::LIMIT_W-1:0] steal_limit;
  logic [pcpf_pkg::PAGE_W-1:0]  lowest_page;
  pcpf_pkg::ctrl_cmd_t          ctrl_cmd;
  pcpf_pkg::dp_status_t         dp_status;

  pcpf_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .steal_limit (steal_limit),
    .lowest_page (lowest_page)
  );

  pcpf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .dp_status (dp_status),
    .ctrl_cmd  (ctrl_cmd)
  );

  pcpf_dpath #(
    .NUM_CPUS  (NUM_CPUS),
    .NUM_PAGES (NUM_PAGES)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .command      (command),
    .cpu_id       (cpu_id),
    .page_index   (page_index),
    .steal_limit  (steal_limit),
    .lowest_page  (lowest_page),
    .ctrl_cmd     (ctrl_cmd),
    .dp_status    (dp_status),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .granted_page (granted_page)
  );

endmodule
